@@ src/lbih_pkg.sv @@
// package: shared constants, types and command codes for the lsh bucket index hash block
`default_nettype none
package lbih_pkg;

  // sizing of the key store and counters
  localparam int MAX_HASHES = 8;
  localparam int MAX_TABLES = 64;
  localparam int KEY_DEPTH  = MAX_HASHES * MAX_TABLES;
  localparam int KEY_W      = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int HPOS_W     = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
  localparam int TPOS_W     = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
  localparam int KCNT_W     = $clog2(MAX_HASHES + 1);
  localparam int LCNT_W     = $clog2(MAX_TABLES + 1);

  // fixed field widths
  localparam int SLOT_W     = 9;
  localparam int WORD_W     = 32;
  localparam int TNUM_W     = 6;
  localparam int BIDX_W     = 30;
  localparam int HASHES_W   = 4;
  localparam int TABLES_W   = 7;
  localparam int RANGE_W    = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam int FOLD_SHIFT = 13;
  localparam int RANGE_MAX  = 30;

  // reset values of the configuration registers
  localparam logic [HASHES_W-1:0] HASHES_RST = 4'd4;
  localparam logic [TABLES_W-1:0] TABLES_RST = 7'd8;
  localparam logic [RANGE_W-1:0]  RANGE_RST  = 5'd22;

  // input command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_HASH = 1'b1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HASHES = 2'd0,
    CFG_TABLES = 2'd1,
    CFG_RANGE  = 2'd2
  } cfg_idx_t;

  // controller to datapath
  typedef struct packed {
    logic load_key;
    logic take_hash;
    logic mul1;
    logic mul2;
    logic acc;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic table_end;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

@@ src/lbih_if.sv @@
// interfaces: hash/load input channel, result channel and configuration write channel
`default_nettype none
interface lbih_in_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [lbih_pkg::SLOT_W-1:0] key_slot;
  logic [lbih_pkg::WORD_W-1:0] value;

  modport source (output valid, command, key_slot, value, input ready);
  modport sink   (input valid, command, key_slot, value, output ready);
endinterface

interface lbih_out_if;
  logic                        valid;
  logic                        ready;
  logic [lbih_pkg::TNUM_W-1:0] table_number;
  logic [lbih_pkg::BIDX_W-1:0] bucket_index;
  logic                        last_table;

  modport source (output valid, table_number, bucket_index, last_table, input ready);
  modport sink   (input valid, table_number, bucket_index, last_table, output ready);
endinterface

interface lbih_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lbih_pkg::CFG_IDX_W-1:0]  index;
  logic [lbih_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ src/lsh_bucket_index_hash_core.sv @@
// top level: lsh bucket index hash core
//
// Folds hashes_per_table hash codes per table into one bucket index for each table.
// items: a beat with command load writes value into key store slot key_slot; a beat
//   with command hash folds value into the running sum of the current table.
// results: one beat per completed table with table_number, bucket_index and
//   last_table; hash beats that do not end a table give no result.
// cfg: register writes (0 hashes_per_table, 1 table_count, 2 range_bits), always
//   ready; write them only while no item is in flight.
// Steps: a load beat is taken in idle; a hash beat passes through key read from the
//   key store ram, first multiply, fold and second multiply, accumulate; the
//   two dependent 32-bit multiplies set these steps. A result appears on the
//   cycle after the accumulate of the table's last hash.
// The result sits in an output register, so the next item is taken while a
//   result waits; if a second table result is ready before the first is taken,
//   the block holds in its accumulate step and stalls the item channel.
// Reset clears counters, running sum, config (4, 8, 22) and result valid; the
//   key store is not cleared and needs loading before use.
`default_nettype none
module lsh_bucket_index_hash_core (
  input wire logic   clk,
  input wire logic   rst,
  lbih_in_if.sink    items,
  lbih_out_if.source results,
  lbih_cfg_if.sink   cfg
);
  lbih_pkg::dp_cmd_t    cmd;
  lbih_pkg::dp_status_t status;

  // configuration writes are always taken
  assign cfg.ready = 1'b1;

  // controller
  lbih_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (items.valid),
    .in_command (items.command),
    .in_ready   (items.ready),
    .status     (status),
    .cmd        (cmd)
  );

  // datapath
  lbih_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .in_key_slot      (items.key_slot),
    .in_value         (items.value),
    .cfg_we           (cfg.valid && cfg.ready),
    .cfg_index        (cfg.index),
    .cfg_data         (cfg.data),
    .out_valid        (results.valid),
    .out_ready        (results.ready),
    .out_table_number (results.table_number),
    .out_bucket_index (results.bucket_index),
    .out_last_table   (results.last_table)
  );
endmodule
`default_nettype wire

@@ src/lbih_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none
module lbih_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                             wdata,
  input  wire logic                                         re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                             rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

@@ src/lbih_ctrl.sv @@
// controller: sequences each hash beat through key fetch, two multiplies and accumulate; a load beat is taken in idle
`default_nettype none
module lbih_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic                 in_command,
  output logic                      in_ready,
  input  wire lbih_pkg::dp_status_t status,
  output lbih_pkg::dp_cmd_t         cmd
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL1 = 4'b0010,
    S_MUL2 = 4'b0100,
    S_ACC  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // next state and commands
  always_comb begin
    state_next    = state;
    cmd           = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_command == lbih_pkg::CMD_LOAD) begin
            cmd.load_key = 1'b1;
          end else begin
            cmd.take_hash = 1'b1;
            state_next    = S_MUL1;
          end
        end
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        // a table result waits for the output register to free up
        if (!status.table_end || status.out_free) begin
          cmd.acc    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule
`default_nettype wire

@@ src/lbih_datapath.sv @@
// datapath: config registers, key store, fold multiplies, running sum and result register
`default_nettype none
module lbih_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire lbih_pkg::dp_cmd_t           cmd,
  output lbih_pkg::dp_status_t             status,
  input  wire logic [lbih_pkg::SLOT_W-1:0] in_key_slot,
  input  wire logic [lbih_pkg::WORD_W-1:0] in_value,
  input  wire logic                        cfg_we,
  input  wire logic [lbih_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lbih_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [lbih_pkg::TNUM_W-1:0]      out_table_number,
  output logic [lbih_pkg::BIDX_W-1:0]      out_bucket_index,
  output logic                             out_last_table
);
  // configuration registers
  logic [lbih_pkg::HASHES_W-1:0] hashes_per_table;
  logic [lbih_pkg::TABLES_W-1:0] table_count;
  logic [lbih_pkg::RANGE_W-1:0]  range_bits;

  // counters and sum
  logic [lbih_pkg::HPOS_W-1:0]   hash_position;
  logic [lbih_pkg::TPOS_W-1:0]   table_position;
  logic [lbih_pkg::WORD_W-1:0]   running_sum;

  // pipeline payload
  logic [lbih_pkg::WORD_W-1:0]   hash_value;
  logic [lbih_pkg::WORD_W-1:0]   key_word;
  logic [lbih_pkg::WORD_W-1:0]   prod1;
  logic [lbih_pkg::WORD_W-1:0]   prod2;
  logic [lbih_pkg::WORD_W-1:0]   ram_rdata;

  logic [lbih_pkg::KCNT_W-1:0]   eff_hashes;
  logic [lbih_pkg::LCNT_W-1:0]   eff_tables;
  logic [lbih_pkg::RANGE_W-1:0]  eff_range;
  logic [lbih_pkg::BIDX_W:0]     range_mask;
  logic [lbih_pkg::KEY_W-1:0]    key_index;
  logic                          slot_ok;
  logic                          last;
  logic [lbih_pkg::WORD_W-1:0]   folded;
  logic [lbih_pkg::WORD_W-1:0]   sum_new;

  // saturate configuration into its working range
  always_comb begin
    if (hashes_per_table == '0) begin
      eff_hashes = lbih_pkg::KCNT_W'(1);
    end else if (hashes_per_table > lbih_pkg::MAX_HASHES) begin
      eff_hashes = lbih_pkg::KCNT_W'(lbih_pkg::MAX_HASHES);
    end else begin
      eff_hashes = lbih_pkg::KCNT_W'(hashes_per_table);
    end
    if (table_count == '0) begin
      eff_tables = lbih_pkg::LCNT_W'(1);
    end else if (table_count > lbih_pkg::MAX_TABLES) begin
      eff_tables = lbih_pkg::LCNT_W'(lbih_pkg::MAX_TABLES);
    end else begin
      eff_tables = lbih_pkg::LCNT_W'(table_count);
    end
    if (range_bits > lbih_pkg::RANGE_MAX) begin
      eff_range = lbih_pkg::RANGE_W'(lbih_pkg::RANGE_MAX);
    end else begin
      eff_range = range_bits;
    end
  end

  assign range_mask = ((lbih_pkg::BIDX_W+1)'(1) << eff_range) - (lbih_pkg::BIDX_W+1)'(1);

  // key slot of the current hash
  assign key_index = lbih_pkg::KEY_W'(table_position) * lbih_pkg::KEY_W'(eff_hashes)
                   + lbih_pkg::KEY_W'(hash_position);
  assign slot_ok   = (in_key_slot < lbih_pkg::KEY_DEPTH);

  // end of table and end of set
  assign status.table_end = (lbih_pkg::KCNT_W'(hash_position) + lbih_pkg::KCNT_W'(1))
                            >= eff_hashes;
  assign last             = (lbih_pkg::LCNT_W'(table_position) + lbih_pkg::LCNT_W'(1))
                            >= eff_tables;
  assign status.out_free  = !out_valid || out_ready;

  // fold of the first product with its shift and the key
  assign folded  = prod1 ^ (prod1 >> lbih_pkg::FOLD_SHIFT) ^ key_word;
  assign sum_new = running_sum + prod2;

  // key store
  lbih_ram #(
    .WIDTH (lbih_pkg::WORD_W),
    .DEPTH (lbih_pkg::KEY_DEPTH)
  ) u_key_store (
    .clk   (clk),
    .we    (cmd.load_key && slot_ok),
    .waddr (in_key_slot[lbih_pkg::KEY_W-1:0]),
    .wdata (in_value),
    .re    (cmd.take_hash),
    .raddr (key_index),
    .rdata (ram_rdata)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      hashes_per_table <= lbih_pkg::HASHES_RST;
      table_count      <= lbih_pkg::TABLES_RST;
      range_bits       <= lbih_pkg::RANGE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lbih_pkg::CFG_HASHES: hashes_per_table <= cfg_data[lbih_pkg::HASHES_W-1:0];
        lbih_pkg::CFG_TABLES: table_count      <= cfg_data[lbih_pkg::TABLES_W-1:0];
        lbih_pkg::CFG_RANGE:  range_bits       <= cfg_data[lbih_pkg::RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  // multiply stages
  always_ff @(posedge clk) begin
    if (cmd.take_hash) begin
      hash_value <= in_value;
    end
    if (cmd.mul1) begin
      key_word <= ram_rdata;
      prod1    <= hash_value * ram_rdata;
    end
    if (cmd.mul2) begin
      prod2 <= folded * hash_value;
    end
  end

  // counters and running sum
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_position  <= '0;
      table_position <= '0;
      running_sum    <= '0;
    end else if (cmd.acc) begin
      if (status.table_end) begin
        hash_position  <= '0;
        running_sum    <= '0;
        table_position <= last ? '0 : table_position + lbih_pkg::TPOS_W'(1);
      end else begin
        hash_position  <= hash_position + lbih_pkg::HPOS_W'(1);
        running_sum    <= sum_new;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.acc && status.table_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc && status.table_end) begin
      out_table_number <= lbih_pkg::TNUM_W'(table_position);
      out_bucket_index <= sum_new[lbih_pkg::BIDX_W-1:0] & range_mask[lbih_pkg::BIDX_W-1:0];
      out_last_table   <= last;
    end
  end
endmodule
`default_nettype wire

@@ tb/tb_lsh_bucket_index_hash_core.sv @@
// testbench: directed script and random phases for the lsh bucket index hash core
module tb_lsh_bucket_index_hash_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int HOLD_CYCLES     = 400;
  localparam int PRESSURE_AT     = 300;
  localparam int STEADY_FROM     = 600;
  localparam int STEADY_TO       = 800;
  localparam int PHASES          = 12;
  localparam int BEATS_PER_PHASE = 100;

  typedef struct packed {
    logic [lbih_pkg::TNUM_W-1:0] tnum;
    logic [lbih_pkg::BIDX_W-1:0] bidx;
    logic                        last;
  } bucket_result_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_HASH} row_kind_t;

  typedef struct packed {
    row_kind_t                   kind;
    lbih_pkg::cfg_idx_t          sel;
    logic [lbih_pkg::SLOT_W-1:0] slot;
    logic [lbih_pkg::WORD_W-1:0] word;
    logic                        typed;
    bucket_result_t              want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst;

  lbih_in_if  items_if ();
  lbih_out_if results_if ();
  lbih_cfg_if cfg_if ();

  lsh_bucket_index_hash_core DUT (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .results (results_if),
    .cfg     (cfg_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // bucket index predictor state
  logic [lbih_pkg::WORD_W-1:0]   key_mem [lbih_pkg::KEY_DEPTH];
  bit                            key_loaded [lbih_pkg::KEY_DEPTH];
  int unsigned                   hpos = 0;
  int unsigned                   tpos = 0;
  logic [lbih_pkg::WORD_W-1:0]   fold_sum = '0;
  logic [lbih_pkg::HASHES_W-1:0] hashes_reg = lbih_pkg::HASHES_RST;
  logic [lbih_pkg::TABLES_W-1:0] tables_reg = lbih_pkg::TABLES_RST;
  logic [lbih_pkg::RANGE_W-1:0]  range_reg = lbih_pkg::RANGE_RST;

  bucket_result_t pending_buckets [$];
  bucket_result_t arrived_want;
  int             mismatches = 0;
  int             quiet_cycles = 0;
  int             beats_sent = 0;
  bit             offering = 0;
  bit             steady = 0;
  bit             hold_request = 0;
  int             hold_left = 0;

  function automatic int unsigned hashes_eff();
    if (hashes_reg == 0) return 1;
    if (hashes_reg > lbih_pkg::MAX_HASHES) return lbih_pkg::MAX_HASHES;
    return hashes_reg;
  endfunction

  function automatic int unsigned key_slot_next();
    return (tpos * hashes_eff() + hpos) % lbih_pkg::KEY_DEPTH;
  endfunction

  // fold one hash code into the running sum; returns 1 when a table closes
  function automatic bit fold_hash(input logic [lbih_pkg::WORD_W-1:0] word,
                                   output bucket_result_t res);
    int unsigned                 k;
    int unsigned                 l;
    int unsigned                 rb;
    logic [lbih_pkg::WORD_W-1:0] key;
    logic [lbih_pkg::WORD_W-1:0] h;
    logic [lbih_pkg::WORD_W-1:0] span_mask;
    k = hashes_eff();
    l = (tables_reg == 0) ? 1 :
        (tables_reg > lbih_pkg::MAX_TABLES) ? lbih_pkg::MAX_TABLES : tables_reg;
    rb = (range_reg > lbih_pkg::RANGE_MAX) ? lbih_pkg::RANGE_MAX : range_reg;
    key = key_mem[key_slot_next()];
    h = word * key;
    h = h ^ (h >> lbih_pkg::FOLD_SHIFT);
    h = h ^ key;
    fold_sum = fold_sum + h * word;
    res = '0;
    if (hpos + 1 < k) begin
      hpos++;
      return 0;
    end
    span_mask = (32'd1 << rb) - 32'd1;
    res.tnum = lbih_pkg::TNUM_W'(tpos);
    res.bidx = lbih_pkg::BIDX_W'(fold_sum & span_mask);
    res.last = (tpos + 1 >= l);
    fold_sum = '0;
    hpos = 0;
    tpos = res.last ? 0 : tpos + 1;
    return 1;
  endfunction

  function automatic bit idle_roll();
    return !steady && ($urandom_range(0, 99) < 19);
  endfunction

  // mostly odd keys, some raw words
  function automatic logic [lbih_pkg::WORD_W-1:0] random_key();
    return ($urandom_range(0, 4) == 0) ? $urandom : ($urandom | 32'd1);
  endfunction

  function automatic logic [lbih_pkg::WORD_W-1:0] random_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  function automatic script_row_t cfg_row(lbih_pkg::cfg_idx_t sel,
                                          logic [lbih_pkg::CFG_DATA_W-1:0] data);
    script_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.sel = sel;
    r.word = lbih_pkg::WORD_W'(data);
    return r;
  endfunction

  function automatic script_row_t load_row(logic [lbih_pkg::SLOT_W-1:0] slot,
                                           logic [lbih_pkg::WORD_W-1:0] word);
    script_row_t r;
    r = '0;
    r.kind = ROW_LOAD;
    r.slot = slot;
    r.word = word;
    return r;
  endfunction

  function automatic script_row_t hash_row(logic [lbih_pkg::WORD_W-1:0] word,
                                           logic typed = 0,
                                           logic [lbih_pkg::TNUM_W-1:0] tnum = '0,
                                           logic [lbih_pkg::BIDX_W-1:0] bidx = '0,
                                           logic last = 0);
    script_row_t r;
    r = '0;
    r.kind = ROW_HASH;
    r.word = word;
    r.typed = typed;
    r.want.tnum = tnum;
    r.want.bidx = bidx;
    r.want.last = last;
    return r;
  endfunction

  // offer one input beat and update the predictor when it is taken
  task automatic put_beat(input logic cmd, input logic [lbih_pkg::SLOT_W-1:0] slot,
                          input logic [lbih_pkg::WORD_W-1:0] word, input bit typed,
                          input bucket_result_t want);
    bucket_result_t got;
    while (idle_roll()) begin
      if (offering) begin
        items_if.valid <= 1'b0;
        offering = 0;
      end
      @(posedge clk);
    end
    items_if.valid    <= 1'b1;
    items_if.command  <= cmd;
    items_if.key_slot <= slot;
    items_if.value    <= word;
    offering = 1;
    do @(posedge clk); while (!items_if.ready);
    if (cmd == lbih_pkg::CMD_LOAD) begin
      key_mem[slot] = word;
      key_loaded[slot] = 1;
    end else if (fold_hash(word, got)) begin
      pending_buckets.push_back(typed ? want : got);
    end
    beats_sent++;
    if (beats_sent == PRESSURE_AT) hold_request = 1;
    steady = (beats_sent >= STEADY_FROM) && (beats_sent < STEADY_TO);
  endtask

  // hash beat; loads the key slot first if it was never written
  task automatic fold_beat(input logic [lbih_pkg::WORD_W-1:0] word, input bit typed,
                           input bucket_result_t want);
    if (!key_loaded[key_slot_next()])
      put_beat(lbih_pkg::CMD_LOAD, lbih_pkg::SLOT_W'(key_slot_next()), random_key(), 0, '0);
    put_beat(lbih_pkg::CMD_HASH,
             lbih_pkg::SLOT_W'($urandom_range(0, lbih_pkg::KEY_DEPTH - 1)),
             word, typed, want);
  endtask

  // stop offering, drain every expected result, let the pipeline empty
  task automatic settle_block();
    if (offering) begin
      items_if.valid <= 1'b0;
      offering = 0;
    end
    while (pending_buckets.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input lbih_pkg::cfg_idx_t sel,
                           input logic [lbih_pkg::CFG_DATA_W-1:0] data);
    settle_block();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= sel;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (sel)
      lbih_pkg::CFG_HASHES: hashes_reg = data[lbih_pkg::HASHES_W-1:0];
      lbih_pkg::CFG_TABLES: tables_reg = data[lbih_pkg::TABLES_W-1:0];
      lbih_pkg::CFG_RANGE:  range_reg  = data[lbih_pkg::RANGE_W-1:0];
      default: ;
    endcase
  endtask

  // result side: random stalls plus one long hold-off
  initial begin
    results_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        results_if.ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 0;
        hold_left = HOLD_CYCLES - 1;
        results_if.ready <= 1'b0;
      end else begin
        results_if.ready <= !idle_roll();
      end
    end
  end

  // result checker and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (results_if.valid && results_if.ready) begin
        if (pending_buckets.size() == 0) begin
          $error("unexpected result beat: table_number %0d bucket_index %0d last_table %0d",
                 results_if.table_number, results_if.bucket_index, results_if.last_table);
          mismatches++;
        end else begin
          arrived_want = pending_buckets.pop_front();
          if (results_if.table_number !== arrived_want.tnum) begin
            $error("table_number: expected %0d, got %0d",
                   arrived_want.tnum, results_if.table_number);
            mismatches++;
          end
          if (results_if.bucket_index !== arrived_want.bidx) begin
            $error("bucket_index: expected %0d, got %0d",
                   arrived_want.bidx, results_if.bucket_index);
            mismatches++;
          end
          if (results_if.last_table !== arrived_want.last) begin
            $error("last_table: expected %0d, got %0d",
                   arrived_want.last, results_if.last_table);
            mismatches++;
          end
        end
      end
      if ((items_if.valid && items_if.ready) || (results_if.valid && results_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin : stimulus
    script_row_t                     script [$];
    int                              phase;
    logic [lbih_pkg::CFG_DATA_W-1:0] kd;
    logic [lbih_pkg::CFG_DATA_W-1:0] ld;
    logic [lbih_pkg::CFG_DATA_W-1:0] rd;

    rst               <= 1'b1;
    items_if.valid    <= 1'b0;
    items_if.command  <= lbih_pkg::CMD_LOAD;
    items_if.key_slot <= '0;
    items_if.value    <= '0;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= lbih_pkg::CFG_HASHES;
    cfg_if.data       <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // one code per table, two tables; zero key and zero code give a zero index
    script.push_back(cfg_row(lbih_pkg::CFG_HASHES, 7'd1));
    script.push_back(cfg_row(lbih_pkg::CFG_TABLES, 7'd2));
    script.push_back(load_row(9'd0, 32'h0000_0000));
    script.push_back(load_row(9'd1, 32'hFFFF_FFFF));
    script.push_back(hash_row(32'hFFFF_FFFF, 1, 6'd0, '0, 1'b0));
    script.push_back(hash_row(32'h0000_0000, 1, 6'd1, '0, 1'b1));
    script.push_back(hash_row(32'h1234_5678, 1, 6'd0, '0, 1'b0));
    // empty mask, counters kept across the write
    script.push_back(cfg_row(lbih_pkg::CFG_RANGE, 7'd0));
    script.push_back(hash_row(32'hDEAD_BEEF, 1, 6'd1, '0, 1'b1));
    // saturating register values
    script.push_back(cfg_row(lbih_pkg::CFG_RANGE, 7'd31));
    script.push_back(cfg_row(lbih_pkg::CFG_HASHES, 7'd0));
    script.push_back(cfg_row(lbih_pkg::CFG_TABLES, 7'd127));
    script.push_back(load_row(9'd0, 32'h9E37_79B9));
    script.push_back(hash_row(32'hFFFF_FFFF));
    script.push_back(load_row(9'd511, 32'hFFFF_FFFF));
    script.push_back(cfg_row(lbih_pkg::CFG_HASHES, 7'd15));
    script.push_back(hash_row(32'h0000_0001));
    // load in the middle of a table, even key word
    script.push_back(load_row(9'd9, 32'h0000_0002));
    script.push_back(hash_row(32'h8000_0000));
    // shrink codes per table mid-table, then close the set early
    script.push_back(cfg_row(lbih_pkg::CFG_HASHES, 7'd2));
    script.push_back(hash_row(32'hA5A5_A5A5));
    script.push_back(cfg_row(lbih_pkg::CFG_TABLES, 7'd1));
    script.push_back(hash_row(32'h7FFF_FFFF));
    script.push_back(hash_row(32'h0000_0000));

    foreach (script[i]) begin
      case (script[i].kind)
        ROW_CFG:  write_reg(script[i].sel, script[i].word[lbih_pkg::CFG_DATA_W-1:0]);
        ROW_LOAD: put_beat(lbih_pkg::CMD_LOAD, script[i].slot, script[i].word, 0, '0);
        default:  fold_beat(script[i].word, script[i].typed, script[i].want);
      endcase
    end

    // random phases, each with its own register setting
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin kd = 7'd8;   ld = 7'd64;  rd = 7'd30;  end
        1: begin kd = 7'd1;   ld = 7'd1;   rd = 7'd1;   end
        2: begin kd = 7'd0;   ld = 7'd0;   rd = 7'd0;   end
        3: begin kd = 7'h7F;  ld = 7'h7F;  rd = 7'h7F;  end
        default: begin
          kd = ($urandom_range(0, 9) == 0) ? lbih_pkg::CFG_DATA_W'($urandom_range(0, 127))
                                           : lbih_pkg::CFG_DATA_W'($urandom_range(1, 8));
          ld = ($urandom_range(0, 9) == 0) ? lbih_pkg::CFG_DATA_W'($urandom_range(0, 127))
                                           : lbih_pkg::CFG_DATA_W'($urandom_range(1, 6));
          rd = lbih_pkg::CFG_DATA_W'($urandom_range(0, 127));
        end
      endcase
      write_reg(lbih_pkg::CFG_HASHES, kd);
      write_reg(lbih_pkg::CFG_TABLES, ld);
      write_reg(lbih_pkg::CFG_RANGE, rd);
      repeat (BEATS_PER_PHASE) begin
        if ($urandom_range(0, 99) < 12)
          put_beat(lbih_pkg::CMD_LOAD,
                   lbih_pkg::SLOT_W'($urandom_range(0, lbih_pkg::KEY_DEPTH - 1)),
                   random_key(), 0, '0);
        else
          fold_beat(random_word(), 0, '0);
      end
    end

    settle_block();
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
